[rtl/svfc_pkg.sv]
`timescale 1ns / 1ps
// svfc_pkg: shared types and constants for the state variable filter cascade core
// no dependencies; used by svfc_mul and state_variable_filter_cascade_core

package svfc_pkg;

  // register field widths
  localparam int FREQ_W  = 20;
  localparam int DAMP_W  = 18;
  localparam int NORM_W  = 17;
  localparam int MODE_W  = 2;
  // damping plus g needs one more bit than the wider of the two
  localparam int COEF_W  = 21;
  // integrator and node width
  localparam int STATE_W = 32;

  // register indexes on the config bus
  localparam logic [1:0] REG_FREQ_GAIN   = 2'd0;
  localparam logic [1:0] REG_DAMPING     = 2'd1;
  localparam logic [1:0] REG_NORM_GAIN   = 2'd2;
  localparam logic [1:0] REG_FILTER_MODE = 2'd3;

  // reset values
  localparam logic [FREQ_W-1:0] FREQ_RST = 20'd13107;
  localparam logic [DAMP_W-1:0] DAMP_RST = 18'd131072;
  localparam logic [NORM_W-1:0] NORM_RST = 17'd50000;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_LP12 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LP24 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HP   = 2'd3;

  // sequencer states: each product has an issue state and a finish state
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM_A,
    ST_NUM_B,
    ST_HP_A,
    ST_HP_B,
    ST_BP_A,
    ST_BP_B,
    ST_LP_A,
    ST_LP_B,
    ST_UPD,
    ST_OUT
  } state_t;

  // multiplier issue control
  typedef struct packed {
    logic              en;
    logic [COEF_W-1:0] coef;
  } mul_ctl_t;

endpackage

[rtl/svfc_if.sv]
`timescale 1ns / 1ps
// svfc_in_if / svfc_out_if: valid/ready sample channels of the filter core
// no dependencies

interface svfc_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface svfc_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/state_variable_filter_cascade_core.sv]
`timescale 1ns / 1ps
// Trapezoidal state variable filter, one or two stages, one shared multiplier.
// One sample at a time: input ready only in idle, so a new sample is taken only after
// the last result is in the output slot. The single multiplier serves four products
// per stage, each with an issue state and a finish state.
// Reset (rst_n, synchronous, active low): integrators cleared, registers to defaults.
// Depends on svfc_pkg, svfc_if.sv and svfc_mul.

module state_variable_filter_cascade_core #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  svfc_in_if.sink     in_ch,
  svfc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW     = svfc_pkg::STATE_W;
  localparam int KS_W   = svfc_pkg::COEF_W + SW - 1;
  // widest value into the multiplier: x - round(kg * s0) - s1
  localparam int NUM_W  = ((KS_W - COEF_FRAC_BITS) > SW ? (KS_W - COEF_FRAC_BITS) : SW) + 2;
  localparam int RND_W  = svfc_pkg::COEF_W + NUM_W - COEF_FRAC_BITS + 1;
  localparam int ACC_W  = (RND_W > NUM_W ? RND_W : NUM_W) + 2;

  localparam logic signed [SW-1:0] S_MAX   = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN   = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] OUT_MAX = S_MAX >>> (SW - SAMPLE_WIDTH);
  localparam logic signed [SW-1:0] OUT_MIN = ~OUT_MAX;

  // configuration registers
  logic [svfc_pkg::FREQ_W-1:0] freq_gain_r;
  logic [svfc_pkg::DAMP_W-1:0] damping_r;
  logic [svfc_pkg::NORM_W-1:0] norm_gain_r;
  logic [svfc_pkg::MODE_W-1:0] filter_mode_r;

  // sequencer
  svfc_pkg::state_t state_r, state_nxt;
  logic             stage_r;
  logic             cascade;
  logic             slot_free;
  logic             in_fire;

  // datapath
  logic [svfc_pkg::COEF_W-1:0] kg_r;
  logic signed [SW-1:0]        x_r, hp_r, bp_r, lp_r;
  logic signed [NUM_W-1:0]     num_r;
  logic signed [SW-1:0]        s10_r, s11_r, s20_r, s21_r;
  logic signed [SW-1:0]        s0_cur, s1_cur, s0_new, s1_new, y_sel;
  logic                        out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;

  // shared multiplier
  svfc_pkg::mul_ctl_t      mul_ctl;
  logic signed [NUM_W-1:0] mul_val;
  logic signed [RND_W-1:0] rnd;

  function automatic logic signed [SW-1:0] sat_s(input logic signed [ACC_W-1:0] v);
    logic signed [SW-1:0] res;
    if (v > ACC_W'(S_MAX)) begin
      res = S_MAX;
    end else if (v < ACC_W'(S_MIN)) begin
      res = S_MIN;
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [SW-1:0] v);
    logic signed [SAMPLE_WIDTH-1:0] res;
    if (v > OUT_MAX) begin
      res = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < OUT_MIN) begin
      res = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      res = v[SAMPLE_WIDTH-1:0];
    end
    return res;
  endfunction

  svfc_mul #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .VAL_W          (NUM_W)
  ) u_mul (
    .clk (clk),
    .ctl (mul_ctl),
    .val (mul_val),
    .rnd (rnd)
  );

  // handshakes
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cascade   = !stage_r && (filter_mode_r == svfc_pkg::MODE_LP24);

  assign in_ch.ready       = (state_r == svfc_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // current stage integrators
  assign s0_cur = stage_r ? s20_r : s10_r;
  assign s1_cur = stage_r ? s21_r : s11_r;

  // trapezoidal integrator update: s' = 2 * node - s
  assign s0_new = sat_s((ACC_W'(bp_r) <<< 1) - ACC_W'(s0_cur));
  assign s1_new = sat_s((ACC_W'(lp_r) <<< 1) - ACC_W'(s1_cur));

  // output node select
  always_comb begin
    case (filter_mode_r) inside
      svfc_pkg::MODE_BP: y_sel = bp_r;
      svfc_pkg::MODE_HP: y_sel = hp_r;
      default:           y_sel = lp_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svfc_pkg::ST_IDLE:  if (in_fire) state_nxt = svfc_pkg::ST_NUM_A;
      svfc_pkg::ST_NUM_A: state_nxt = svfc_pkg::ST_NUM_B;
      svfc_pkg::ST_NUM_B: state_nxt = svfc_pkg::ST_HP_A;
      svfc_pkg::ST_HP_A:  state_nxt = svfc_pkg::ST_HP_B;
      svfc_pkg::ST_HP_B:  state_nxt = svfc_pkg::ST_BP_A;
      svfc_pkg::ST_BP_A:  state_nxt = svfc_pkg::ST_BP_B;
      svfc_pkg::ST_BP_B:  state_nxt = svfc_pkg::ST_LP_A;
      svfc_pkg::ST_LP_A:  state_nxt = svfc_pkg::ST_LP_B;
      svfc_pkg::ST_LP_B:  state_nxt = svfc_pkg::ST_UPD;
      svfc_pkg::ST_UPD:   state_nxt = cascade ? svfc_pkg::ST_NUM_A : svfc_pkg::ST_OUT;
      svfc_pkg::ST_OUT:   if (slot_free) state_nxt = svfc_pkg::ST_IDLE;
      default:            state_nxt = svfc_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_ctl.en   = 1'b0;
    mul_ctl.coef = kg_r;
    mul_val      = NUM_W'(s0_cur);
    unique case (state_r)
      svfc_pkg::ST_NUM_A: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.coef = kg_r;
        mul_val      = NUM_W'(s0_cur);
      end
      svfc_pkg::ST_HP_A: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.coef = svfc_pkg::COEF_W'(norm_gain_r);
        mul_val      = num_r;
      end
      svfc_pkg::ST_BP_A: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.coef = svfc_pkg::COEF_W'(freq_gain_r);
        mul_val      = NUM_W'(hp_r);
      end
      svfc_pkg::ST_LP_A: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.coef = svfc_pkg::COEF_W'(freq_gain_r);
        mul_val      = NUM_W'(bp_r);
      end
      default: begin
        mul_ctl.en = 1'b0;
      end
    endcase
  end

  // control, integrators and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= svfc_pkg::ST_IDLE;
      stage_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      s10_r         <= '0;
      s11_r         <= '0;
      s20_r         <= '0;
      s21_r         <= '0;
      freq_gain_r   <= svfc_pkg::FREQ_RST;
      damping_r     <= svfc_pkg::DAMP_RST;
      norm_gain_r   <= svfc_pkg::NORM_RST;
      filter_mode_r <= svfc_pkg::MODE_LP12;
    end else begin
      state_r <= state_nxt;

      // stage select
      if (in_fire) begin
        stage_r <= 1'b0;
      end else if (state_r == svfc_pkg::ST_UPD && cascade) begin
        stage_r <= 1'b1;
      end

      // integrator write-back
      if (state_r == svfc_pkg::ST_UPD) begin
        if (stage_r) begin
          s20_r <= s0_new;
          s21_r <= s1_new;
        end else begin
          s10_r <= s0_new;
          s11_r <= s1_new;
        end
      end

      // output slot
      if (state_r == svfc_pkg::ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // register writes
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[3:2])
          svfc_pkg::REG_FREQ_GAIN:   freq_gain_r   <= pwdata[svfc_pkg::FREQ_W-1:0];
          svfc_pkg::REG_DAMPING:     damping_r     <= pwdata[svfc_pkg::DAMP_W-1:0];
          svfc_pkg::REG_NORM_GAIN:   norm_gain_r   <= pwdata[svfc_pkg::NORM_W-1:0];
          svfc_pkg::REG_FILTER_MODE: filter_mode_r <= pwdata[svfc_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // node registers
  always_ff @(posedge clk) begin
    case (state_r)
      svfc_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_r  <= SW'(in_ch.sample_in);
          kg_r <= svfc_pkg::COEF_W'(damping_r) + svfc_pkg::COEF_W'(freq_gain_r);
        end
      end
      svfc_pkg::ST_NUM_B: num_r <= NUM_W'(ACC_W'(x_r) - ACC_W'(rnd) - ACC_W'(s1_cur));
      svfc_pkg::ST_HP_B:  hp_r  <= sat_s(ACC_W'(rnd));
      svfc_pkg::ST_BP_B:  bp_r  <= sat_s(ACC_W'(rnd) + ACC_W'(s0_cur));
      svfc_pkg::ST_LP_B:  lp_r  <= sat_s(ACC_W'(rnd) + ACC_W'(s1_cur));
      svfc_pkg::ST_UPD: begin
        // stage one lowpass feeds stage two
        if (cascade) begin
          x_r <= lp_r;
        end
      end
      svfc_pkg::ST_OUT: begin
        if (slot_free) begin
          out_data_r <= sat_out(y_sel);
        end
      end
      default: ;
    endcase
  end

  // register read-back
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      svfc_pkg::REG_FREQ_GAIN:   prdata = 32'(freq_gain_r);
      svfc_pkg::REG_DAMPING:     prdata = 32'(damping_r);
      svfc_pkg::REG_NORM_GAIN:   prdata = 32'(norm_gain_r);
      svfc_pkg::REG_FILTER_MODE: prdata = 32'(filter_mode_r);
      default:                   prdata = '0;
    endcase
  end

endmodule

[rtl/svfc_mul.sv]
`timescale 1ns / 1ps
// svfc_mul: shared coefficient by value multiplier with registered product
// and round-to-nearest (ties up) scaling; depends on svfc_pkg

module svfc_mul #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int VAL_W          = 38
) (
  input  logic                                           clk,
  input  svfc_pkg::mul_ctl_t                             ctl,
  input  logic signed [VAL_W-1:0]                        val,
  output logic signed [svfc_pkg::COEF_W+VAL_W-COEF_FRAC_BITS:0] rnd
);

  localparam int PROD_W = svfc_pkg::COEF_W + 1 + VAL_W;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_rnd;

  // coefficient is unsigned: zero-extend into a signed operand
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= PROD_W'($signed({1'b0, ctl.coef}) * val);
    end
  end

  // add half an lsb and drop the fraction bits (floor shift)
  assign prod_rnd = prod_r + HALF;
  assign rnd      = prod_rnd[PROD_W-1:COEF_FRAC_BITS];

endmodule

[sim/state_variable_filter_cascade_core_tb.sv]
`timescale 1ns / 1ps
// state_variable_filter_cascade_core_tb: self-checking bench for the filter core, with a bit-exact
// fixed-point filter predictor, apb register programming and random valid/ready stalls
// depends on svfc_pkg, svfc_if.sv and state_variable_filter_cascade_core

module state_variable_filter_cascade_core_tb;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int TARGET_SAMPLES = 1900;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 400;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // filter predictor and queue of expected output samples
  class sample_scoreboard;
    logic [svfc_pkg::FREQ_W-1:0] freq_gain;
    logic [svfc_pkg::DAMP_W-1:0] damping;
    logic [svfc_pkg::NORM_W-1:0] norm_gain;
    logic [svfc_pkg::MODE_W-1:0] filter_mode;
    longint            integ [2][2];
    sample_t           expected_samples [$];
    int                mismatches;
    int                results_checked;

    function new();
      freq_gain       = svfc_pkg::FREQ_RST;
      damping         = svfc_pkg::DAMP_RST;
      norm_gain       = svfc_pkg::NORM_RST;
      filter_mode     = svfc_pkg::MODE_LP12;
      mismatches      = 0;
      results_checked = 0;
      for (int s = 0; s < 2; s++) begin
        integ[s][0] = 0;
        integ[s][1] = 0;
      end
    endfunction

    // only the register width is kept
    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        svfc_pkg::REG_FREQ_GAIN:   freq_gain   = value[svfc_pkg::FREQ_W-1:0];
        svfc_pkg::REG_DAMPING:     damping     = value[svfc_pkg::DAMP_W-1:0];
        svfc_pkg::REG_NORM_GAIN:   norm_gain   = value[svfc_pkg::NORM_W-1:0];
        svfc_pkg::REG_FILTER_MODE: filter_mode = value[svfc_pkg::MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // exact product, round to nearest with ties toward plus infinity
    function longint round_mul(longint coef, longint v);
      longint p;
      p = coef * v + (longint'(1) << (COEF_FRAC_BITS - 1));
      return p >>> COEF_FRAC_BITS;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // one trapezoidal svf stage, integrators updated in place
    function void run_stage(int s, longint x, output longint hp, output longint bp,
                            output longint lp);
      longint g;
      longint kg;
      longint num;
      g   = longint'(freq_gain);
      kg  = longint'(damping) + g;
      num = x - round_mul(kg, integ[s][0]) - integ[s][1];
      hp  = clamp(round_mul(longint'(norm_gain), num), svfc_pkg::STATE_W);
      bp  = clamp(round_mul(g, hp) + integ[s][0], svfc_pkg::STATE_W);
      lp  = clamp(round_mul(g, bp) + integ[s][1], svfc_pkg::STATE_W);
      integ[s][0] = clamp(2 * bp - integ[s][0], svfc_pkg::STATE_W);
      integ[s][1] = clamp(2 * lp - integ[s][1], svfc_pkg::STATE_W);
    endfunction

    // stage two only runs in the 24 dB mode and is otherwise left untouched
    function sample_t filter_sample(sample_t x);
      longint hp1, bp1, lp1, hp2, bp2, lp2, y;
      run_stage(0, longint'(x), hp1, bp1, lp1);
      case (filter_mode)
        svfc_pkg::MODE_LP24: begin
          run_stage(1, lp1, hp2, bp2, lp2);
          y = lp2;
        end
        svfc_pkg::MODE_BP: y = bp1;
        svfc_pkg::MODE_HP: y = hp1;
        default: y = lp1;
      endcase
      return sample_t'(clamp(y, SAMPLE_WIDTH));
    endfunction

    function void note_input(sample_t x);
      expected_samples.push_back(filter_sample(x));
    endfunction

    function void check_output(sample_t y);
      sample_t want;
      if (expected_samples.size() == 0) begin
        $error("sample_out: transaction with none expected, expected none, actual %0d", y);
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      if (y !== want) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want, y);
        mismatches++;
      end
      results_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit          steady;
  int          samples_sent;
  sample_t     last_sample;

  sample_scoreboard sb = new();

  svfc_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_if ();
  svfc_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_if ();

  state_variable_filter_cascade_core #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // apb write: setup then access, psel left high for a following transfer
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0h, actual %0h", idx, want, prdata);
      sb.mismatches++;
    end
    penable <= 1'b0;
  endtask

  // write every register and read it back
  task automatic program_filter(input logic [31:0] f, input logic [31:0] d,
                                input logic [31:0] n, input logic [31:0] m);
    apb_write(svfc_pkg::REG_FREQ_GAIN, f);
    check_reg(svfc_pkg::REG_FREQ_GAIN, 32'(f[svfc_pkg::FREQ_W-1:0]));
    apb_write(svfc_pkg::REG_DAMPING, d);
    check_reg(svfc_pkg::REG_DAMPING, 32'(d[svfc_pkg::DAMP_W-1:0]));
    apb_write(svfc_pkg::REG_NORM_GAIN, n);
    check_reg(svfc_pkg::REG_NORM_GAIN, 32'(n[svfc_pkg::NORM_W-1:0]));
    apb_write(svfc_pkg::REG_FILTER_MODE, m);
    check_reg(svfc_pkg::REG_FILTER_MODE, 32'(m[svfc_pkg::MODE_W-1:0]));
    psel <= 1'b0;
  endtask

  // mostly musical settings with a matching norm gain, the rest raw bus values
  task automatic random_settings();
    logic [31:0] f;
    logic [31:0] d;
    logic [31:0] n;
    longint      den;
    if ($urandom_range(99) < 70) begin
      f   = $urandom_range(200, 200000);
      d   = $urandom_range(13107, 131072);
      den = 65536 + ((longint'(d) * longint'(f)) >>> 16) + ((longint'(f) * longint'(f)) >>> 16);
      n   = 32'((longint'(1) << 32) / den);
    end else begin
      f = $urandom;
      d = $urandom;
      n = $urandom;
    end
    program_filter(f, d, n, $urandom);
  endtask

  // send one transaction; valid stays high after acceptance until the next decision
  task automatic send_sample(input sample_t x);
    while (!steady && $urandom_range(99) < 22) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(x);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // noise, small signals, held steps, full-scale and inverted swings
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 35) last_sample = sample_t'($urandom);
    else if (r < 60) last_sample = sample_t'(int'($urandom_range(0, 8192)) - 4096);
    else if (r < 75) last_sample = last_sample;
    else if (r < 85) last_sample = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    else last_sample = ~last_sample;
    return last_sample;
  endfunction

  // result side: random stalls plus one long hold-off while the sender is offering
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) sb.check_output(out_if.sample_out);
      if (!held && sb.results_checked >= HOLD_AT && in_if.valid) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n || hold_left > 0) begin
        out_if.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 22);
      end
    end
  end

  // watchdog on cycles with no transaction and no bus activity
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("state_variable_filter_cascade_core_tb failed");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    int phase;
    int count;
    phase           = 0;
    steady          = 0;
    samples_sent    = 0;
    last_sample     = '0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values read back, then the reset setting with full-scale steps
    check_reg(svfc_pkg::REG_FREQ_GAIN, 32'(svfc_pkg::FREQ_RST));
    check_reg(svfc_pkg::REG_DAMPING, 32'(svfc_pkg::DAMP_RST));
    check_reg(svfc_pkg::REG_NORM_GAIN, 32'(svfc_pkg::NORM_RST));
    check_reg(svfc_pkg::REG_FILTER_MODE, 32'(svfc_pkg::MODE_LP12));
    psel <= 1'b0;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    wait_drained();

    // largest gains with bits above the register widths: nodes and states saturate
    program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFC | 32'(svfc_pkg::MODE_LP24));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    wait_drained();

    // same gains in bandpass, stage two kept as it is
    program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(svfc_pkg::MODE_BP));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    wait_drained();

    // zero cutoff and zero norm gain in highpass
    program_filter(32'd0, 32'd13107, 32'd0, 32'(svfc_pkg::MODE_HP));
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    wait_drained();

    // damping below its range, unity norm: highpass gives the input minus the second integrator
    program_filter(32'd0, 32'd0, 32'd65536, 32'(svfc_pkg::MODE_HP));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'h555555);
    wait_drained();

    // back to the default coefficients in the cascade, stage two resumes
    program_filter(32'(svfc_pkg::FREQ_RST), 32'(svfc_pkg::DAMP_RST), 32'(svfc_pkg::NORM_RST),
                   32'(svfc_pkg::MODE_LP24));
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(1));
    wait_drained();

    // random settings, each followed by a burst of samples
    while (samples_sent < TARGET_SAMPLES) begin
      random_settings();
      steady = (phase == 3);
      count  = $urandom_range(40, 160);
      repeat (count) send_sample(pick_sample());
      steady = 0;
      wait_drained();
      phase++;
    end

    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("state_variable_filter_cascade_core_tb passed");
    end else begin
      $display("state_variable_filter_cascade_core_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/svfc_pkg.sv
rtl/svfc_if.sv
rtl/svfc_mul.sv
rtl/state_variable_filter_cascade_core.sv
sim/state_variable_filter_cascade_core_tb.sv
